/* design/apm_pkg.sv */
package apm_pkg;

    localparam int MaxRankDef    = 4;
    localparam int StoreDepthDef = 4096;

    localparam int IdxW     = 12;
    localparam int ValW     = 64;
    localparam int DimW     = 13;
    localparam int RankW    = 3;
    localparam int PermW    = 8;
    localparam int AxisW    = 2;
    localparam int NumAxes  = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 13;

    localparam int DivSteps  = 2;
    localparam int DivStages = IdxW / DivSteps;

    localparam logic [DimW-1:0] ProdCap = DimW'(1 << IdxW);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RANK = 3'd0,
        CFG_DIM0 = 3'd1,
        CFG_DIM1 = 3'd2,
        CFG_DIM2 = 3'd3,
        CFG_DIM3 = 3'd4,
        CFG_PERM = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic            operation;
        logic [IdxW-1:0] index;
        logic [ValW-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic [ValW-1:0] value_out;
        logic [IdxW-1:0] source_index;
        logic            error;
    } rsp_word_t;

    typedef struct packed {
        logic                          vld;
        logic                          op;
        logic                          err;
        logic [IdxW-1:0]               idx;
        logic [ValW-1:0]               val;
        logic [IdxW-1:0]               quo;
        logic [NumAxes-1:0][DimW-1:0]  coord;
    } item_t;

    function automatic logic [DimW-1:0] sat_mul(input logic [DimW-1:0] a,
                                                input logic [DimW-1:0] b);
        logic [2*DimW-1:0] p;
        p = (2*DimW)'(a) * (2*DimW)'(b);
        if (p > (2*DimW)'(ProdCap))
            return ProdCap;
        return p[DimW-1:0];
    endfunction

endpackage

/* design/apm_div.sv */
module apm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [apm_pkg::DimW-1:0]  ext,
    input  logic                      en,
    input  logic [apm_pkg::AxisW-1:0] ax,
    input  apm_pkg::item_t            din,
    output apm_pkg::item_t            dout
);

    localparam int Stages = apm_pkg::DivStages;
    localparam int DimW   = apm_pkg::DimW;
    localparam int IdxW   = apm_pkg::IdxW;

    apm_pkg::item_t  st_reg  [Stages];
    apm_pkg::item_t  st_next [Stages];
    logic [DimW-1:0] rem_reg [Stages];
    logic [DimW-1:0] rem_next[Stages];

    always_comb
    begin
        apm_pkg::item_t  it;
        logic [DimW-1:0] rem;
        logic [DimW:0]   r;
        for (int s = 0; s < Stages; s++)
        begin
            if (s == 0)
            begin
                it  = din;
                rem = '0;
            end
            else
            begin
                it  = st_reg[s-1];
                rem = rem_reg[s-1];
            end
            for (int t = 0; t < apm_pkg::DivSteps; t++)
            begin
                r      = {rem, it.quo[IdxW-1]};
                it.quo = {it.quo[IdxW-2:0], 1'b0};
                if (r >= {1'b0, ext})
                begin
                    r         = r - {1'b0, ext};
                    it.quo[0] = 1'b1;
                end
                rem = r[DimW-1:0];
            end
            st_next[s]  = it;
            rem_next[s] = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Stages; s++)
            begin
                st_reg[s]  <= '0;
                rem_reg[s] <= '0;
            end
        end
        else if (advance)
        begin
            for (int s = 0; s < Stages; s++)
            begin
                st_reg[s]  <= st_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    always_comb
    begin
        dout = st_reg[Stages-1];
        if (en)
            dout.coord[ax] = rem_reg[Stages-1];
    end

endmodule

/* design/apm_store.sv */
module apm_store #(
    parameter int Depth = apm_pkg::StoreDepthDef
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic                      we,
    input  logic [$clog2(Depth)-1:0]  addr,
    input  logic [apm_pkg::ValW-1:0]  wdata,
    output logic [apm_pkg::ValW-1:0]  rdata
);

    logic [apm_pkg::ValW-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            rdata <= mem[addr];
        end
    end

endmodule

/* design/array_axis_permute.sv */
// Channel  Signals                                 Word
// req      req_valid, req_ready, req               operation, index, value
// rsp      rsp_valid, rsp_ready, rsp               value_out, source_index, error
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write, always ready
//
// One word per cycle sustained; each word passes from req to rsp through
// one entry stage, six radix-2-bit divider stages per output axis, three
// multiply-add stages rebuilding the source address, one store read stage.
// A stall on rsp freezes the whole pipeline and holds req_ready low.
// After a register write req_ready is held low while the registered
// extent product settles.
// rst_n clears control state only; the element store is not cleared.
module array_axis_permute #(
    parameter int MaxRank    = apm_pkg::MaxRankDef,
    parameter int StoreDepth = apm_pkg::StoreDepthDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  apm_pkg::req_word_t           req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output apm_pkg::rsp_word_t           rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [apm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [apm_pkg::CfgDataW-1:0] cfg_data
);

    localparam int DimW  = apm_pkg::DimW;
    localparam int IdxW  = apm_pkg::IdxW;
    localparam int RankW = apm_pkg::RankW;
    localparam int NAx   = apm_pkg::NumAxes;
    localparam int AddrW = $clog2(StoreDepth);
    localparam int SrcW  = AddrW + 1;
    localparam int SumW  = SrcW + DimW + 1;

    logic [RankW-1:0]         rank_reg;
    logic [DimW-1:0]          dim_reg [NAx];
    logic [apm_pkg::PermW-1:0] perm_reg;
    logic [DimW-1:0]          p1_reg, p2_reg, p3_reg;
    logic [1:0]               hold_reg;

    logic [DimW-1:0]          dim_eff [NAx];
    logic                     rank_ok, perm_ok, advance, accept;

    apm_pkg::item_t           s0_reg, s0_next;
    apm_pkg::item_t           div_item [NAx+1];
    apm_pkg::item_t           h_reg  [3];
    apm_pkg::item_t           h_next [3];
    logic [SrcW-1:0]          hsrc_reg  [3];
    logic [SrcW-1:0]          hsrc_next [3];

    logic                     m_vld_reg, m_op_reg, m_err_reg;
    logic [IdxW-1:0]          m_idx_reg;
    logic [SrcW-1:0]          m_src_reg;
    logic [apm_pkg::ValW-1:0] rdata;
    logic                     st_we;
    logic [AddrW-1:0]         st_addr;

    assign cfg_ready = 1'b1;
    assign advance   = !m_vld_reg || rsp_ready;
    assign req_ready = advance && (hold_reg == 2'd0);
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= RankW'(1);
            for (int k = 0; k < NAx; k++)
                dim_reg[k] <= DimW'(1);
            perm_reg <= 8'd228;
            hold_reg <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hold_reg <= 2'd3;
            case (apm_pkg::cfg_reg_t'(cfg_index))
                apm_pkg::CFG_RANK: rank_reg   <= cfg_data[RankW-1:0];
                apm_pkg::CFG_DIM0: dim_reg[0] <= cfg_data;
                apm_pkg::CFG_DIM1: dim_reg[1] <= cfg_data;
                apm_pkg::CFG_DIM2: dim_reg[2] <= cfg_data;
                apm_pkg::CFG_DIM3: dim_reg[3] <= cfg_data;
                apm_pkg::CFG_PERM: perm_reg   <= cfg_data[apm_pkg::PermW-1:0];
                default: ;
            endcase
        end
        else if (hold_reg != 2'd0)
            hold_reg <= hold_reg - 2'd1;
    end

    always_comb
    begin
        for (int k = 0; k < NAx; k++)
            dim_eff[k] = (RankW'(k) < rank_reg) ? dim_reg[k] : DimW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= DimW'(1);
            p2_reg <= DimW'(1);
            p3_reg <= DimW'(1);
        end
        else
        begin
            p1_reg <= apm_pkg::sat_mul(dim_eff[0], dim_eff[1]);
            p2_reg <= apm_pkg::sat_mul(p1_reg, dim_eff[2]);
            p3_reg <= apm_pkg::sat_mul(p2_reg, dim_eff[3]);
        end
    end

    assign rank_ok = (rank_reg != '0) && (32'(rank_reg) <= MaxRank);

    always_comb
    begin
        logic [NAx-1:0]               seen;
        logic [apm_pkg::AxisW-1:0]    ax;
        seen    = '0;
        perm_ok = 1'b1;
        for (int j = 0; j < NAx; j++)
        begin
            ax = perm_reg[2*j +: 2];
            if (RankW'(j) < rank_reg)
            begin
                if (RankW'(ax) >= rank_reg || seen[ax])
                    perm_ok = 1'b0;
                seen[ax] = 1'b1;
            end
        end
    end

    always_comb
    begin
        s0_next       = '0;
        s0_next.vld   = accept;
        s0_next.op    = req.operation;
        s0_next.idx   = req.index;
        s0_next.val   = req.value;
        s0_next.quo   = req.index;
        s0_next.err   = !rank_ok || ({1'b0, req.index} >= p3_reg)
                        || (32'(req.index) >= StoreDepth)
                        || (req.operation == apm_pkg::OP_READ && !perm_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_reg <= '0;
        else if (advance)
            s0_reg <= s0_next;
    end

    assign div_item[0] = s0_reg;

    for (genvar j = 0; j < NAx; j++)
    begin : g_div
        logic [apm_pkg::AxisW-1:0] ax;
        logic                      en;
        assign ax = perm_reg[2*j +: 2];
        assign en = RankW'(j) < rank_reg;

        apm_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ext     (en ? dim_reg[ax] : DimW'(1)),
            .en      (en),
            .ax      (ax),
            .din     (div_item[j]),
            .dout    (div_item[j+1])
        );
    end

    always_comb
    begin
        apm_pkg::item_t  it;
        logic [SrcW-1:0] src;
        logic [SumW-1:0] sum;
        for (int g = 0; g < 3; g++)
        begin
            if (g == 0)
            begin
                it  = div_item[NAx];
                if (it.op == apm_pkg::OP_READ && 32'(it.coord[3]) >= StoreDepth)
                    it.err = 1'b1;
                src = SrcW'(it.coord[3]);
            end
            else
            begin
                it  = h_reg[g-1];
                src = hsrc_reg[g-1];
            end
            sum = SumW'(src) * SumW'(dim_eff[2-g]) + SumW'(it.coord[2-g]);
            if (it.op == apm_pkg::OP_READ && sum >= SumW'(StoreDepth))
                it.err = 1'b1;
            h_next[g]    = it;
            hsrc_next[g] = SrcW'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < 3; g++)
            begin
                h_reg[g]    <= '0;
                hsrc_reg[g] <= '0;
            end
        end
        else if (advance)
        begin
            for (int g = 0; g < 3; g++)
            begin
                h_reg[g]    <= h_next[g];
                hsrc_reg[g] <= hsrc_next[g];
            end
        end
    end

    assign st_we   = advance && h_reg[2].vld && !h_reg[2].err
                     && h_reg[2].op == apm_pkg::OP_WRITE;
    assign st_addr = (h_reg[2].op == apm_pkg::OP_WRITE) ? AddrW'(h_reg[2].idx)
                                                        : AddrW'(hsrc_reg[2]);

    apm_store #(
        .Depth (StoreDepth)
    ) u_store (
        .clk   (clk),
        .en    (advance),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (h_reg[2].val),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            m_op_reg  <= 1'b0;
            m_err_reg <= 1'b0;
            m_idx_reg <= '0;
            m_src_reg <= '0;
        end
        else if (advance)
        begin
            m_vld_reg <= h_reg[2].vld;
            m_op_reg  <= h_reg[2].op;
            m_err_reg <= h_reg[2].err;
            m_idx_reg <= h_reg[2].idx;
            m_src_reg <= hsrc_reg[2];
        end
    end

    assign rsp_valid        = m_vld_reg;
    assign rsp.error        = m_err_reg;
    assign rsp.value_out    = (!m_err_reg && m_op_reg == apm_pkg::OP_READ) ? rdata : '0;
    assign rsp.source_index = m_err_reg ? '0
                              : (m_op_reg == apm_pkg::OP_WRITE) ? m_idx_reg
                              : IdxW'(m_src_reg);

    a_cfg_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> !req_ready)
        else $error("request taken right after a register write");

    a_src_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_vld_reg && !m_err_reg && m_op_reg == apm_pkg::OP_READ
        |-> 32'(m_src_reg) < StoreDepth)
        else $error("source address beyond store passed without error");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> rsp.value_out == '0 && rsp.source_index == '0)
        else $error("rejected word carries data");

endmodule
